[rtl/assert_macros.svh]
// Assertion macros for the arc point and normal generator.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_LAT(lbl, ante, n, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##n (cons)) \
    else $error("latency assertion failed");
`else
`define ASSERT_IMP(lbl, ante, cons)
`define ASSERT_LAT(lbl, ante, n, cons)
`endif
`endif

[rtl/apng_pkg.sv]
// Package of the arc point and normal generator: sizes, constants, tables.
// No dependencies.
package apng_pkg;

  localparam int CORDIC_STAGES = 24;
  localparam int DATA_WIDTH    = 32;

  // Iterations actually built and the saturation width.
  localparam int CordicIter = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  localparam int SatW = (DATA_WIDTH > 32) ? 32 : ((DATA_WIDTH < 2) ? 2 : DATA_WIDTH);
  localparam int Latency = CordicIter + 9;

  // Widths of the CORDIC datapath and of the result datapath.
  localparam int ZW = 34;
  localparam int RW = 40;

  // Register indexes.
  localparam logic [2:0] CFG_CENTER_REAL = 3'd0;
  localparam logic [2:0] CFG_CENTER_IMAG = 3'd1;
  localparam logic [2:0] CFG_ARC_RADIUS  = 3'd2;
  localparam logic [2:0] CFG_ANGLE_START = 3'd3;
  localparam logic [2:0] CFG_ANGLE_SPAN  = 3'd4;

  localparam logic [31:0] RadToTurn = 32'd2734261102;
  localparam logic signed [ZW-1:0] InvGain = 34'sd652032874;
  localparam logic signed [ZW-1:0] OneQ30 = 34'sd1073741824;

  localparam logic signed [RW-1:0] SatHi = (40'sd1 <<< (SatW - 1)) - 40'sd1;
  localparam logic signed [RW-1:0] SatLo = -(40'sd1 <<< (SatW - 1));

  // Arctangent of 2^-i as a binary angle, 2^32 per full turn.
  function automatic logic [31:0] turn_atan(input int idx);
    logic [31:0] v;
    case (idx)
      0: v = 32'd536870912;
      1: v = 32'd316933406;
      2: v = 32'd167458907;
      3: v = 32'd85004756;
      4: v = 32'd42667331;
      5: v = 32'd21354465;
      6: v = 32'd10679838;
      7: v = 32'd5340245;
      8: v = 32'd2670163;
      9: v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      24: v = 32'd41;
      25: v = 32'd20;
      26: v = 32'd10;
      27: v = 32'd5;
      28: v = 32'd3;
      29: v = 32'd1;
      30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // Saturate to SatW bits and sign-extend to a 32-bit port.
  function automatic logic [31:0] sat32(input logic signed [RW-1:0] v);
    logic signed [RW-1:0] r;
    if (v > SatHi) begin
      r = SatHi;
    end else if (v < SatLo) begin
      r = SatLo;
    end else begin
      r = v;
    end
    return r[31:0];
  endfunction

endpackage

[rtl/arc_point_normal_generator_top.sv]
// Top level of the arc point and normal generator: angle pipeline, CORDIC, products.
// Depends on apng_pkg and assert_macros.svh.
//
// One parameter beat enters on every cycle (busy_o stays low) and its result leaves
// from the last stage (Stage I), one done_o pulse per beat; the receiver
// must take each result in that cycle. The depth is set by one pipeline stage per
// CORDIC iteration plus four stages of angle arithmetic and five of products,
// rounding and saturation. The user must write configuration only while no beat is
// in flight; the block does not enforce it. Radius times span is kept registered.
`include "assert_macros.svh"

module arc_point_normal_generator_top
  import apng_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic signed [31:0] param_t_i,
  output logic        done_o,
  output logic signed [31:0] point_real_o,
  output logic signed [31:0] point_imag_o,
  output logic signed [31:0] deriv_real_o,
  output logic signed [31:0] deriv_imag_o,
  output logic signed [31:0] normal_real_o,
  output logic signed [31:0] normal_imag_o,
  output logic        degenerate_o
);

  logic accept;
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;

  // Configuration registers.
  logic signed [31:0] center_real_q, center_imag_q, arc_radius_q, angle_start_q, angle_span_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_real_q <= '0;
      center_imag_q <= '0;
      arc_radius_q  <= 32'sd65536;
      angle_start_q <= '0;
      angle_span_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CENTER_REAL: center_real_q <= cfg_data_i;
        CFG_CENTER_IMAG: center_imag_q <= cfg_data_i;
        CFG_ARC_RADIUS:  arc_radius_q  <= cfg_data_i;
        CFG_ANGLE_START: angle_start_q <= cfg_data_i;
        CFG_ANGLE_SPAN:  angle_span_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Values that follow from the configuration alone.
  logic signed [63:0] rsprod_q;
  logic signed [63:0] rsround;
  logic [35:0] rs_mag_q;
  logic rs_neg_q;
  logic [31:0] rad_mag_q;
  logic rad_neg_q, degen_q, nflip_q;

  assign rsround = rsprod_q + 64'sd134217728;

  always_ff @(posedge clk_i) begin
    rsprod_q  <= 64'(arc_radius_q) * 64'(angle_span_q);
    rs_neg_q  <= rsround[63];
    rs_mag_q  <= rsround[63] ? 36'(-rsround[63:28]) : rsround[63:28];
    rad_neg_q <= arc_radius_q[31];
    rad_mag_q <= arc_radius_q[31] ? 32'(-arc_radius_q) : arc_radius_q;
    degen_q   <= (arc_radius_q == 32'sd0) || (angle_span_q == 32'sd0);
    nflip_q   <= arc_radius_q[31] ^ angle_span_q[31];
  end

  // Valid bits of the angle stages, the CORDIC stages and the result stages.
  logic a_vld_q, b_vld_q, c_vld_q, e_vld_q, f_vld_q, g_vld_q, h_vld_q, i_vld_q;
  logic cv_q [CordicIter+1];

  // Stage A: t times span.
  logic signed [63:0] a_prod_q;
  always_ff @(posedge clk_i) begin
    a_prod_q <= 64'(param_t_i) * 64'(angle_span_q);
  end

  // Stage B: add the start angle and round to Q.28.
  logic signed [63:0] b_sum;
  logic signed [33:0] b_a28_q;
  assign b_sum = {{2{angle_start_q[31]}}, angle_start_q, 30'd0} + a_prod_q
                 + 64'sd536870912;
  always_ff @(posedge clk_i) begin
    b_a28_q <= b_sum[63:30];
  end

  // Stage C: scale to a binary angle, low word and top bits apart.
  logic signed [34:0] c_hi;
  logic [63:0] c_lo_q;
  logic [29:0] c_hi_q;
  assign c_hi = 35'($signed(b_a28_q[33:32])) * 35'($signed({1'b0, RadToTurn}));
  always_ff @(posedge clk_i) begin
    c_lo_q <= 64'(b_a28_q[31:0]) * 64'(RadToTurn);
    c_hi_q <= c_hi[29:0];
  end

  // Stage D: round the binary angle and fold it into the right half plane.
  logic [61:0] d_p;
  logic signed [ZW-1:0] d_z;
  logic signed [ZW-1:0] cx_q [CordicIter+1];
  logic signed [ZW-1:0] cy_q [CordicIter+1];
  logic signed [ZW-1:0] cz_q [CordicIter+1];
  logic cf_q [CordicIter+1];

  assign d_p = c_lo_q[61:0] + {c_hi_q, 32'd0} + 62'd536870912;
  assign d_z = {{2{d_p[61]}}, d_p[61:30]};

  always_ff @(posedge clk_i) begin
    cx_q[0] <= InvGain;
    cy_q[0] <= '0;
    if (d_z > OneQ30) begin
      cz_q[0] <= d_z - 34'sd2147483648;
      cf_q[0] <= 1'b1;
    end else if (d_z < -OneQ30) begin
      cz_q[0] <= d_z + 34'sd2147483648;
      cf_q[0] <= 1'b1;
    end else begin
      cz_q[0] <= d_z;
      cf_q[0] <= 1'b0;
    end
  end

  // CORDIC rotation, one iteration per stage.
  for (genvar g = 0; g < CordicIter; g++) begin : g_cordic
    logic signed [ZW-1:0] atan_w;
    assign atan_w = $signed({2'b00, turn_atan(g)});
    always_ff @(posedge clk_i) begin
      cf_q[g+1] <= cf_q[g];
      if (!cz_q[g][ZW-1]) begin
        cx_q[g+1] <= cx_q[g] - (cy_q[g] >>> g);
        cy_q[g+1] <= cy_q[g] + (cx_q[g] >>> g);
        cz_q[g+1] <= cz_q[g] - atan_w;
      end else begin
        cx_q[g+1] <= cx_q[g] + (cy_q[g] >>> g);
        cy_q[g+1] <= cy_q[g] - (cx_q[g] >>> g);
        cz_q[g+1] <= cz_q[g] + atan_w;
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[g+1] <= 1'b0;
      end else begin
        cv_q[g+1] <= cv_q[g];
      end
    end
  end

  // Stage E: undo the fold and clamp cos and sin to one.
  logic signed [ZW-1:0] e_x, e_y, e_xc, e_yc;
  logic signed [31:0] e_c_q, e_s_q;
  assign e_x = cf_q[CordicIter] ? -cx_q[CordicIter] : cx_q[CordicIter];
  assign e_y = cf_q[CordicIter] ? -cy_q[CordicIter] : cy_q[CordicIter];
  always_comb begin
    e_xc = (e_x > OneQ30) ? OneQ30 : ((e_x < -OneQ30) ? -OneQ30 : e_x);
    e_yc = (e_y > OneQ30) ? OneQ30 : ((e_y < -OneQ30) ? -OneQ30 : e_y);
  end
  always_ff @(posedge clk_i) begin
    e_c_q <= e_xc[31:0];
    e_s_q <= e_yc[31:0];
  end

  // Stage F: magnitudes and signs of cos and sin, and the normal.
  logic [30:0] f_cm_q, f_sm_q;
  logic f_cn_q, f_sn_q;
  logic signed [31:0] f_nr_q, f_ni_q, g_nr_q, g_ni_q, h_nr_q, h_ni_q;
  logic f_dg_q, g_dg_q, h_dg_q;
  always_ff @(posedge clk_i) begin
    f_cn_q <= e_c_q[31];
    f_sn_q <= e_s_q[31];
    f_cm_q <= e_c_q[31] ? 31'(-e_c_q) : e_c_q[30:0];
    f_sm_q <= e_s_q[31] ? 31'(-e_s_q) : e_s_q[30:0];
    f_dg_q <= degen_q;
    if (degen_q) begin
      f_nr_q <= '0;
      f_ni_q <= '0;
    end else if (nflip_q) begin
      f_nr_q <= -e_c_q;
      f_ni_q <= -e_s_q;
    end else begin
      f_nr_q <= e_c_q;
      f_ni_q <= e_s_q;
    end
  end

  // Stage G: the four magnitude products.
  logic [66:0] g_pr_q, g_pi_q, g_dr_q, g_di_q;
  logic g_pr_n_q, g_pi_n_q, g_dr_n_q, g_di_n_q;
  always_ff @(posedge clk_i) begin
    g_pr_q <= 67'(rad_mag_q) * 67'(f_cm_q);
    g_pi_q <= 67'(rad_mag_q) * 67'(f_sm_q);
    g_dr_q <= 67'(rs_mag_q) * 67'(f_sm_q);
    g_di_q <= 67'(rs_mag_q) * 67'(f_cm_q);
    g_pr_n_q <= rad_neg_q ^ f_cn_q;
    g_pi_n_q <= rad_neg_q ^ f_sn_q;
    g_dr_n_q <= ~(rs_neg_q ^ f_sn_q);
    g_di_n_q <= rs_neg_q ^ f_cn_q;
    g_nr_q <= f_nr_q;
    g_ni_q <= f_ni_q;
    g_dg_q <= f_dg_q;
  end

  // Stage H: round half away from zero and apply the sign.
  function automatic logic signed [RW-1:0] round_sign(input logic [66:0] m, input logic neg);
    logic [66:0] r;
    logic signed [RW-1:0] v;
    r = m + 67'd536870912;
    v = $signed({3'b000, r[66:30]});
    return neg ? -v : v;
  endfunction

  logic signed [RW-1:0] h_pr_q, h_pi_q, h_dr_q, h_di_q;
  always_ff @(posedge clk_i) begin
    h_pr_q <= round_sign(g_pr_q, g_pr_n_q);
    h_pi_q <= round_sign(g_pi_q, g_pi_n_q);
    h_dr_q <= round_sign(g_dr_q, g_dr_n_q);
    h_di_q <= round_sign(g_di_q, g_di_n_q);
    h_nr_q <= g_nr_q;
    h_ni_q <= g_ni_q;
    h_dg_q <= g_dg_q;
  end

  // Stage I: add the center and saturate into the output registers.
  logic signed [RW-1:0] i_cr, i_ci;
  assign i_cr = {{(RW-32){center_real_q[31]}}, center_real_q};
  assign i_ci = {{(RW-32){center_imag_q[31]}}, center_imag_q};
  always_ff @(posedge clk_i) begin
    point_real_o  <= sat32(i_cr + h_pr_q);
    point_imag_o  <= sat32(i_ci + h_pi_q);
    deriv_real_o  <= sat32(h_dr_q);
    deriv_imag_o  <= sat32(h_di_q);
    normal_real_o <= h_nr_q;
    normal_imag_o <= h_ni_q;
    degenerate_o  <= h_dg_q;
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      cv_q[0] <= 1'b0;
      e_vld_q <= 1'b0;
      f_vld_q <= 1'b0;
      g_vld_q <= 1'b0;
      h_vld_q <= 1'b0;
      i_vld_q <= 1'b0;
    end else begin
      a_vld_q <= accept;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      cv_q[0] <= c_vld_q;
      e_vld_q <= cv_q[CordicIter];
      f_vld_q <= e_vld_q;
      g_vld_q <= f_vld_q;
      h_vld_q <= g_vld_q;
      i_vld_q <= h_vld_q;
    end
  end

  assign done_o = i_vld_q;

  // Checks on results and pipeline depth.
  `ASSERT_IMP(a_degen_zero, done_o && degenerate_o, normal_real_o == 32'sd0 && normal_imag_o == 32'sd0)
  `ASSERT_IMP(a_norm_range, done_o, normal_real_o <= 32'sd1073741824 && normal_real_o >= -32'sd1073741824)
  `ASSERT_LAT(a_latency, accept, Latency, done_o)

endmodule

[verif/tb_top.sv]
// Self-checking testbench for arc_point_normal_generator_top.
// Depends on apng_pkg; predicts each beat in SystemVerilog and compares every field.

module tb_top;
  import apng_pkg::*;

  typedef enum logic [1:0] {JOB_BEAT, JOB_CFG, JOB_DRAIN, JOB_PACE} job_kind_e;

  typedef struct {
    job_kind_e   kind;
    logic [2:0]  idx;
    logic [31:0] data;
  } job_t;

  typedef struct {
    logic signed [31:0] pt_re;
    logic signed [31:0] pt_im;
    logic signed [31:0] dv_re;
    logic signed [31:0] dv_im;
    logic signed [31:0] nm_re;
    logic signed [31:0] nm_im;
    logic               degen;
  } arc_sample_t;

  // Arctangent of 2^-i in binary-angle units (2^32 per turn).
  localparam longint AtanTurn [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0};
  localparam longint SpanPi = 843314857;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = CFG_CENTER_REAL;
  logic [31:0] cfg_data_i = '0;
  logic signed [31:0] param_t_i = '0;
  logic        done_o;
  logic signed [31:0] point_real_o, point_imag_o, deriv_real_o, deriv_imag_o;
  logic signed [31:0] normal_real_o, normal_imag_o;
  logic        degenerate_o;

  // Predictor copy of the configuration registers.
  logic signed [31:0] arc_center_re = 0, arc_center_im = 0;
  logic signed [31:0] arc_rad = 65536, arc_start = 0, arc_span = 0;

  job_t        stim_jobs[$];
  arc_sample_t arc_expected[$];
  int          errors = 0;
  int          send_idle_pct = 0;
  int          quiet_cycles = 0;
  int          since_cfg = 100;

  always #6 clk_i = ~clk_i;

  arc_point_normal_generator_top DUT (.*);

  // a * trig / 2^30, rounded half away from zero.
  function automatic longint scale_q30(longint a, longint trig);
    bit          neg;
    bit [63:0]   m, tr, q, r, res;
    neg = (a < 0) != (trig < 0);
    m = (a < 0) ? -a : a;
    tr = (trig < 0) ? -trig : trig;
    q = m * (tr >> 2);
    r = m * (tr & 64'd3);
    res = (q + ((r + (64'd1 << 29)) >> 2)) >> 28;
    return neg ? -longint'(res) : longint'(res);
  endfunction

  function automatic longint clip_out(longint v);
    if (v > longint'(SatHi)) return longint'(SatHi);
    if (v < longint'(SatLo)) return longint'(SatLo);
    return v;
  endfunction

  // Expected point, derivative and normal for one parameter value.
  function automatic arc_sample_t predict_arc(logic signed [31:0] t);
    arc_sample_t o;
    longint      a58, a28, z, x, y, dx, dy, c, s, rs, rad, span;
    bit [63:0]   p;
    bit [31:0]   ph;
    bit          flip, degen;
    rad = arc_rad;
    span = arc_span;
    a58 = longint'(arc_start) * (64'sd1 <<< 30) + longint'(t) * span;
    a28 = (a58 + (64'sd1 <<< 29)) >>> 30;
    p = 64'(a28) * 64'd2734261102;
    ph = 32'((p + (64'd1 << 29)) >> 30);
    z = longint'(signed'(ph));
    flip = 1'b0;
    if (z > (64'sd1 <<< 30)) begin
      z -= 64'sd1 <<< 31;
      flip = 1'b1;
    end else if (z < -(64'sd1 <<< 30)) begin
      z += 64'sd1 <<< 31;
      flip = 1'b1;
    end
    x = 652032874;
    y = 0;
    for (int i = 0; i < CordicIter; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= AtanTurn[i];
      end else begin
        x += dx; y -= dy; z += AtanTurn[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
    if (c > (64'sd1 <<< 30)) c = 64'sd1 <<< 30;
    if (c < -(64'sd1 <<< 30)) c = -(64'sd1 <<< 30);
    if (s > (64'sd1 <<< 30)) s = 64'sd1 <<< 30;
    if (s < -(64'sd1 <<< 30)) s = -(64'sd1 <<< 30);
    rs = (rad * span + (64'sd1 <<< 27)) >>> 28;
    degen = (rad == 0) || (span == 0);
    o.pt_re = 32'(clip_out(longint'(arc_center_re) + scale_q30(rad, c)));
    o.pt_im = 32'(clip_out(longint'(arc_center_im) + scale_q30(rad, s)));
    o.dv_re = 32'(clip_out(-scale_q30(rs, s)));
    o.dv_im = 32'(clip_out(scale_q30(rs, c)));
    if (degen) begin
      o.nm_re = 0; o.nm_im = 0;
    end else if ((rad < 0) != (span < 0)) begin
      o.nm_re = 32'(-c); o.nm_im = 32'(-s);
    end else begin
      o.nm_re = 32'(c); o.nm_im = 32'(s);
    end
    o.degen = degen;
    return o;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $time);
    errors++;
  endtask

  task automatic add_cfg(logic [2:0] idx, logic [31:0] data);
    stim_jobs.push_back('{JOB_CFG, idx, data});
  endtask

  task automatic add_beat(logic [31:0] t);
    stim_jobs.push_back('{JOB_BEAT, CFG_CENTER_REAL, t});
  endtask

  task automatic add_arc(logic [31:0] cr, logic [31:0] ci, logic [31:0] rad,
                         logic [31:0] st, logic [31:0] sp);
    stim_jobs.push_back('{JOB_DRAIN, CFG_CENTER_REAL, 0});
    add_cfg(CFG_CENTER_REAL, cr);
    add_cfg(CFG_CENTER_IMAG, ci);
    add_cfg(CFG_ARC_RADIUS, rad);
    add_cfg(CFG_ANGLE_START, st);
    add_cfg(CFG_ANGLE_SPAN, sp);
  endtask

  // Mostly ordinary values, sometimes an extreme.
  function automatic logic [31:0] pick_reg();
    case ($urandom_range(9))
      0: return 32'h0;
      1: return 32'h7fffffff;
      2: return 32'h80000000;
      default: return $urandom;
    endcase
  endfunction

  // Driver: presents the head job at the falling edge.
  always @(negedge clk_i) begin
    logic nxt_start, nxt_we;
    nxt_start = 1'b0;
    nxt_we = 1'b0;
    if (rst_ni && stim_jobs.size() > 0) begin
      case (stim_jobs[0].kind)
        JOB_PACE: begin
          send_idle_pct = stim_jobs[0].data;
          void'(stim_jobs.pop_front());
        end
        JOB_DRAIN: begin
          if (arc_expected.size() == 0) void'(stim_jobs.pop_front());
        end
        JOB_CFG: begin
          if (arc_expected.size() == 0 && quiet_cycles >= Latency + 2) begin
            nxt_we = 1'b1;
            cfg_idx_i <= stim_jobs[0].idx;
            cfg_data_i <= stim_jobs[0].data;
          end
        end
        default: begin
          if (since_cfg >= 4 && $urandom_range(99) >= send_idle_pct) begin
            nxt_start = 1'b1;
            param_t_i <= stim_jobs[0].data;
          end
        end
      endcase
    end
    start_i <= nxt_start;
    cfg_we_i <= nxt_we;
  end

  // Accepted beats and register writes update the predictor.
  always @(posedge clk_i) begin
    if (rst_ni && cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CENTER_REAL: arc_center_re = cfg_data_i;
        CFG_CENTER_IMAG: arc_center_im = cfg_data_i;
        CFG_ARC_RADIUS:  arc_rad = cfg_data_i;
        CFG_ANGLE_START: arc_start = cfg_data_i;
        default:         arc_span = cfg_data_i;
      endcase
      void'(stim_jobs.pop_front());
      since_cfg <= 0;
      quiet_cycles <= 0;
    end else if (rst_ni && start_i && !busy_o) begin
      arc_expected.push_back(predict_arc(param_t_i));
      void'(stim_jobs.pop_front());
      since_cfg <= since_cfg + 1;
      quiet_cycles <= 0;
    end else begin
      since_cfg <= since_cfg + 1;
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Monitor: each strobed result is checked against the oldest expectation.
  always @(posedge clk_i) begin
    arc_sample_t w;
    if (rst_ni && done_o) begin
      if (arc_expected.size() == 0) begin
        $display("unexpected result at %0t", $time);
        errors++;
      end else begin
        w = arc_expected.pop_front();
        if (point_real_o !== w.pt_re) report_mismatch("point_real", point_real_o, w.pt_re);
        if (point_imag_o !== w.pt_im) report_mismatch("point_imag", point_imag_o, w.pt_im);
        if (deriv_real_o !== w.dv_re) report_mismatch("deriv_real", deriv_real_o, w.dv_re);
        if (deriv_imag_o !== w.dv_im) report_mismatch("deriv_imag", deriv_imag_o, w.dv_im);
        if (normal_real_o !== w.nm_re) report_mismatch("normal_real", normal_real_o, w.nm_re);
        if (normal_imag_o !== w.nm_im) report_mismatch("normal_imag", normal_imag_o, w.nm_im);
        if (degenerate_o !== w.degen) report_mismatch("degenerate", degenerate_o, w.degen);
      end
    end
  end

  // Stimulus plan and end of run.
  initial begin
    logic [31:0] dir_t [9];
    dir_t = '{32'h0, 32'h7fffffff, 32'h80000000, 32'h40000000, 32'hc0000000,
              32'h1, 32'hffffffff, 32'h20000000, 32'h55555555};
    // Reset configuration: span is zero, so every beat is degenerate.
    for (int i = 0; i < 3; i++) add_beat(dir_t[i]);
    // Half-circle sweep with a plain radius, including the fold boundaries.
    add_arc(0, 0, 32'd655360, 0, 32'(SpanPi));
    for (int i = 0; i < 9; i++) add_beat(dir_t[i]);
    // Every register at an extreme: saturation and angle wrap.
    add_arc(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    for (int i = 0; i < 5; i++) add_beat(dir_t[i]);
    // Zero radius with a negative span, then a negative radius.
    add_arc(32'h80000000, 32'h7fffffff, 0, 32'h7fffffff, 32'h80000000);
    for (int i = 0; i < 3; i++) add_beat(dir_t[i]);
    add_arc(32'h10000, 32'hffff0000, 32'h80000000, 32'(SpanPi / 2), 32'(SpanPi));
    for (int i = 0; i < 4; i++) add_beat(dir_t[i]);
    // Random part in three idling regimes.
    for (int ph = 0; ph < 6; ph++) begin
      stim_jobs.push_back('{JOB_PACE, CFG_CENTER_REAL, (ph < 2) ? 30 : ((ph < 4) ? 76 : 0)});
      add_arc(pick_reg(), pick_reg(), pick_reg(), pick_reg(), pick_reg());
      for (int k = 0; k < 95; k++) begin
        if (k == 50) stim_jobs.push_back('{JOB_DRAIN, CFG_CENTER_REAL, 0});
        add_beat(($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h40000000));
      end
    end
    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
    while (stim_jobs.size() > 0 || arc_expected.size() > 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #3000000;
    $display("FAILURE");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/apng_pkg.sv
rtl/arc_point_normal_generator_top.sv
verif/tb_top.sv
